@@ design/stfg_pkg.sv @@
// ============================================================================
// stfg_pkg: shared types and constants for the sighting table
// Item layouts, operation codes, register indexes and the
// controller/datapath interface structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package stfg_pkg;

    localparam int unsigned MAC_W   = 48;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned WALL_W  = 32;
    localparam int unsigned HITS_W  = 32;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [1:0] OP_NOTE  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_GRACE  = 1'd1;

    // Five minutes in microseconds.
    localparam logic [TIME_W-1:0] DEFAULT_GATE_US = 48'd300000000;

    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

    typedef struct packed {
        logic [1:0]        op;
        logic [MAC_W-1:0]  mac_address;
        logic [7:0]        class_code;
        logic signed [7:0] signal_strength;
        logic [TIME_W-1:0] now_us;
        logic [WALL_W-1:0] wall_seconds;
        logic              force_write;
    } in_item_t;

    typedef struct packed {
        logic               write_now;
        logic               matched;
        logic               evicted;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] entry_count;
        logic [HITS_W-1:0]  hit_count;
        logic signed [7:0]  best_rssi;
    } out_item_t;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [7:0]        cls;
        logic signed [7:0] rssi;
        logic [HITS_W-1:0] hits;
        logic [WALL_W-1:0] last_wall;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic rd_issue;
        logic cmp_step;
        logic do_insert;
        logic do_update;
        logic do_flush;
        logic do_misc;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_note;
        logic is_flush;
        logic count_zero;
        logic scan_last;
        logic hit;
        logic out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

@@ design/sighting_table_with_flush_gate.sv @@
// ============================================================================
// sighting_table_with_flush_gate: device sighting table with persist gate
// Notes sightings into a small table, decides when the table should be
// written out, and clears it on request.
// ============================================================================
//
//   Channel | Ports                       | Carries
//   --------+-----------------------------+----------------------------------
//   input   | s_valid, s_ready, s_item    | one operation item (in_item_t)
//   result  | m_valid, m_ready, m_item    | one result item (out_item_t)
//   config  | cfg_valid, cfg_ready,       | register index and 48-bit value
//           | cfg_index, cfg_data         |
//
// A note scans the stored entries one by one, a read step then a compare step
// for each, through the single read port of the entry memory; a match ends
// the scan early. One item is in work at a time; a finished result waits in
// the output register while the next item is accepted, and that item's last
// step stalls until the waiting result is taken. Reset is synchronous and
// needs no clearing pass. Configuration writes are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none

module sighting_table_with_flush_gate #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire stfg_pkg::in_item_t    s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output stfg_pkg::out_item_t        m_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [stfg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stfg_pkg::TIME_W-1:0]    cfg_data
);
    import stfg_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    stfg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    stfg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

@@ design/stfg_ctrl.sv @@
// ============================================================================
// stfg_ctrl: sequencing controller for the sighting table
// Decodes each item and steps the datapath through the table scan and the
// final insert or update, flush decision, or clear or ignored item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stfg_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire stfg_pkg::ctl_sts_t sts,
    output stfg_pkg::ctl_cmd_t      cmd
);
    import stfg_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_READ   = 8'b0000_0100,
        ST_CMP    = 8'b0000_1000,
        ST_INSERT = 8'b0001_0000,
        ST_UPDATE = 8'b0010_0000,
        ST_FLUSH  = 8'b0100_0000,
        ST_MISC   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_note) begin
                    state_next = sts.count_zero ? ST_INSERT : ST_READ;
                end else if (sts.is_flush) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_MISC;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp_step = 1'b1;
                if (sts.hit) begin
                    state_next = ST_UPDATE;
                end else if (sts.scan_last) begin
                    state_next = ST_INSERT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_INSERT: begin
                if (sts.out_free) begin
                    cmd.do_insert = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    cmd.do_update = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.do_flush = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MISC: begin
                if (sts.out_free) begin
                    cmd.do_misc = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/stfg_datapath.sv @@
// ============================================================================
// stfg_datapath: table storage, scan registers and flush gate
// Holds the entry memory, the count and pending flags, the configuration
// registers and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stfg_datapath #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire stfg_pkg::in_item_t    s_item,
    input  wire logic                  cfg_valid,
    input  wire logic [stfg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [stfg_pkg::TIME_W-1:0]    cfg_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output stfg_pkg::out_item_t        m_item,
    input  wire stfg_pkg::ctl_cmd_t    cmd,
    output stfg_pkg::ctl_sts_t         sts
);
    import stfg_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];

    in_item_t          item_reg;
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  min_idx_reg;
    logic [WALL_W-1:0] min_wall_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              struct_pend_reg;
    logic              soft_pend_reg;
    logic [TIME_W-1:0] last_write_reg;
    logic              last_write_valid_reg;
    logic [TIME_W-1:0] min_interval_reg;
    logic [TIME_W-1:0] clock_grace_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;
    out_item_t         m_item_next;

    logic              hit;
    logic              full;
    logic              result_load;
    logic [IDX_W-1:0]  insert_slot;
    logic [CNT_W-1:0]  count_after_insert;
    entry_t            new_entry;
    entry_t            upd_entry;
    logic              flush_go;
    logic              pending;
    logic              interval_block;
    logic              grace_block;
    logic [TIME_W-1:0] since_write;
    logic [IDX_W+SLOT_W-1:0]   slot_wide_scan;
    logic [IDX_W+SLOT_W-1:0]   slot_wide_ins;
    logic [CNT_W+COUNT_W-1:0]  cnt_wide_cur;
    logic [CNT_W+COUNT_W-1:0]  cnt_wide_ins;

    assign hit  = (rd_data_reg.cls == item_reg.class_code) &&
                  (rd_data_reg.mac == item_reg.mac_address);
    assign full = (count_reg == FULL_COUNT);

    assign insert_slot        = full ? min_idx_reg : count_reg[IDX_W-1:0];
    assign count_after_insert = full ? count_reg : count_reg + CNT_W'(1);

    assign result_load = cmd.do_insert || cmd.do_update || cmd.do_flush || cmd.do_misc;

    assign sts.is_note    = (item_reg.op == OP_NOTE) && (item_reg.class_code != 8'd0);
    assign sts.is_flush   = (item_reg.op == OP_FLUSH);
    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_last  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.hit        = hit;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        new_entry.mac       = item_reg.mac_address;
        new_entry.cls       = item_reg.class_code;
        new_entry.rssi      = item_reg.signal_strength;
        new_entry.hits      = HITS_W'(1);
        new_entry.last_wall = item_reg.wall_seconds;

        upd_entry = rd_data_reg;
        if (rd_data_reg.hits != HITS_MAX) begin
            upd_entry.hits = rd_data_reg.hits + HITS_W'(1);
        end
        if (item_reg.wall_seconds != '0) begin
            upd_entry.last_wall = item_reg.wall_seconds;
        end
        if (item_reg.signal_strength > rd_data_reg.rssi) begin
            upd_entry.rssi = item_reg.signal_strength;
        end
    end

    // Flush gate: something must be pending, then the interval and
    // clock-grace gates may each hold the write back.
    always_comb begin
        since_write    = item_reg.now_us - last_write_reg;
        pending        = struct_pend_reg || (item_reg.force_write && soft_pend_reg);
        interval_block = !item_reg.force_write && last_write_valid_reg &&
                         ((item_reg.now_us < last_write_reg) ||
                          (since_write < min_interval_reg));
        grace_block    = (item_reg.wall_seconds == '0) &&
                         (item_reg.now_us < clock_grace_reg);
        flush_go       = pending && !interval_block && !grace_block;
    end

    // Result fields are masked to their port widths for any table depth.
    assign slot_wide_scan = {{SLOT_W{1'b0}}, scan_idx_reg};
    assign slot_wide_ins  = {{SLOT_W{1'b0}}, insert_slot};
    assign cnt_wide_cur   = {{COUNT_W{1'b0}}, count_reg};
    assign cnt_wide_ins   = {{COUNT_W{1'b0}}, count_after_insert};

    always_comb begin
        m_item_next = '0;
        if (cmd.do_insert) begin
            m_item_next.evicted     = full;
            m_item_next.slot_index  = slot_wide_ins[SLOT_W-1:0];
            m_item_next.entry_count = cnt_wide_ins[COUNT_W-1:0];
            m_item_next.hit_count   = HITS_W'(1);
            m_item_next.best_rssi   = item_reg.signal_strength;
        end else if (cmd.do_update) begin
            m_item_next.matched     = 1'b1;
            m_item_next.slot_index  = slot_wide_scan[SLOT_W-1:0];
            m_item_next.entry_count = cnt_wide_cur[COUNT_W-1:0];
            m_item_next.hit_count   = upd_entry.hits;
            m_item_next.best_rssi   = upd_entry.rssi;
        end else if (cmd.do_flush) begin
            m_item_next.write_now   = flush_go;
            m_item_next.entry_count = cnt_wide_cur[COUNT_W-1:0];
        end else if (cmd.do_misc) begin
            if (item_reg.op != OP_CLEAR) begin
                m_item_next.entry_count = cnt_wide_cur[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
        if (cmd.do_insert) begin
            mem[insert_slot] <= new_entry;
        end
        if (cmd.do_update) begin
            mem[scan_idx_reg] <= upd_entry;
        end
        if (cmd.cmp_step) begin
            if ((scan_idx_reg == '0) || (rd_data_reg.last_wall < min_wall_reg)) begin
                min_wall_reg <= rd_data_reg.last_wall;
                min_idx_reg  <= scan_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg         <= '0;
            count_reg            <= '0;
            struct_pend_reg      <= 1'b0;
            soft_pend_reg        <= 1'b0;
            last_write_reg       <= '0;
            last_write_valid_reg <= 1'b0;
            min_interval_reg     <= DEFAULT_GATE_US;
            clock_grace_reg      <= DEFAULT_GATE_US;
            m_valid_reg          <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                    CFG_CLOCK_GRACE:  clock_grace_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // A new result may be loaded in the same cycle the old one leaves.
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cmd.load_item) begin
                scan_idx_reg <= '0;
            end else if (cmd.cmp_step && !hit && !sts.scan_last) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            if (cmd.do_insert) begin
                count_reg       <= count_after_insert;
                struct_pend_reg <= 1'b1;
            end
            if (cmd.do_update) begin
                soft_pend_reg <= 1'b1;
            end
            if (cmd.do_flush) begin
                if (flush_go) begin
                    last_write_reg       <= item_reg.now_us;
                    last_write_valid_reg <= 1'b1;
                    struct_pend_reg      <= 1'b0;
                    soft_pend_reg        <= 1'b0;
                end
            end
            if (cmd.do_misc) begin
                if (item_reg.op == OP_CLEAR) begin
                    count_reg       <= '0;
                    struct_pend_reg <= 1'b0;
                    soft_pend_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire
